// File: rtl/qalm_pkg.sv
// Package for the quad attitude level mixer.
// Holds shared widths, the CORDIC angle table, key codes and the queue entry type.
// No dependencies.
package qalm_pkg;

    localparam int CordicSteps  = 16;
    localparam int AngleFrac    = 8;
    localparam int OffsetLimit  = 1023;
    localparam int HalfTurn     = 180 * (1 << AngleFrac);
    localparam int StepW        = $clog2(CordicSteps + 1);

    localparam logic [7:0] KeyEsc   = 8'h1B;
    localparam logic [7:0] KeyBrack = 8'h5B;
    localparam logic [7:0] KeySpace = 8'h20;

    localparam logic [2:0] CfgStep  = 3'd0;
    localparam logic [2:0] CfgHome  = 3'd1;
    localparam logic [2:0] CfgAlpha = 3'd2;
    localparam logic [2:0] CfgDead  = 3'd3;
    localparam logic [2:0] CfgGain  = 3'd4;

    typedef struct packed {
        logic        mode;
        logic [7:0]  cmd;
        logic [15:0] ax;
        logic [15:0] ay;
        logic [15:0] az;
    } t_item;

    typedef struct packed {
        logic [6:0]  step;
        logic [7:0]  home;
        logic [8:0]  alpha;
        logic [11:0] dead;
        logic [5:0]  gain;
    } t_cfg;

    function automatic logic signed [31:0] atan_entry(input logic [4:0] i);
        case (i)
            5'd0:  atan_entry = 32'sd2949120;
            5'd1:  atan_entry = 32'sd1740967;
            5'd2:  atan_entry = 32'sd919879;
            5'd3:  atan_entry = 32'sd466945;
            5'd4:  atan_entry = 32'sd234379;
            5'd5:  atan_entry = 32'sd117304;
            5'd6:  atan_entry = 32'sd58666;
            5'd7:  atan_entry = 32'sd29335;
            5'd8:  atan_entry = 32'sd14668;
            5'd9:  atan_entry = 32'sd7334;
            5'd10: atan_entry = 32'sd3667;
            5'd11: atan_entry = 32'sd1833;
            5'd12: atan_entry = 32'sd917;
            5'd13: atan_entry = 32'sd458;
            5'd14: atan_entry = 32'sd229;
            5'd15: atan_entry = 32'sd115;
            5'd16: atan_entry = 32'sd57;
            5'd17: atan_entry = 32'sd29;
            5'd18: atan_entry = 32'sd14;
            5'd19: atan_entry = 32'sd7;
            5'd20: atan_entry = 32'sd4;
            5'd21: atan_entry = 32'sd2;
            5'd22: atan_entry = 32'sd1;
            default: atan_entry = 32'sd0;
        endcase
    endfunction

endpackage

// File: rtl/quad_attitude_level_mixer.sv
// Top level of the quad attitude level mixer.
// Depends on qalm_pkg, qalm_queue and qalm_back.
//
// Usage: items enter on the s_axis channel. tuser is the mode (0 command byte,
// 1 sensor tick). tdata packs command_byte, accel_x, accel_y, accel_z from bit 0.
// A command byte updates the offsets and gives no result. A sensor tick gives one
// result on m_axis: tdata packs the four PWM levels (front right first), then the
// 17-bit pitch and roll estimates, zero-filled to 72 bits.
// Configuration writes use i_cfg_valid/o_cfg_ready with a register index.
// A two-entry queue decouples the input from the back end, so the input can
// accept items while a result waits. A sensor tick result is computed by two
// 16-step CORDIC passes on one shared unit plus filter, correction and mix
// steps; the back end takes no new item until the tick's result is registered.
// Results are held while m_axis_tready is low; the back end keeps taking command
// bytes but holds the next tick at its mix step, and then the queue fills.
// Synchronous reset restores register defaults, offsets and empties the queue.
module quad_attitude_level_mixer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,  // command_byte, accel_x, accel_y, accel_z
    input  logic        s_axis_tuser,  // mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,  // pwm fr, fl, br, bl, pitch_estimate, roll_estimate
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [11:0] i_cfg_data
);
    qalm_pkg::t_cfg  r_cfg;
    qalm_pkg::t_item in_item, q_item;
    logic q_full, q_empty, q_pop, push;
    logic [7:0]  fr, fl, br, bl;
    logic [16:0] pe, re;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step  <= 7'd10;
            r_cfg.home  <= 8'd128;
            r_cfg.alpha <= 9'd51;
            r_cfg.dead  <= 12'd512;
            r_cfg.gain  <= 6'd6;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                qalm_pkg::CfgStep:  r_cfg.step  <= i_cfg_data[6:0];
                qalm_pkg::CfgHome:  r_cfg.home  <= i_cfg_data[7:0];
                qalm_pkg::CfgAlpha: r_cfg.alpha <= i_cfg_data[8:0];
                qalm_pkg::CfgDead:  r_cfg.dead  <= i_cfg_data[11:0];
                qalm_pkg::CfgGain:  r_cfg.gain  <= i_cfg_data[5:0];
                default: ;
            endcase
        end
    end

    assign in_item.mode = s_axis_tuser;
    assign in_item.cmd  = s_axis_tdata[7:0];
    assign in_item.ax   = s_axis_tdata[23:8];
    assign in_item.ay   = s_axis_tdata[39:24];
    assign in_item.az   = s_axis_tdata[55:40];
    assign s_axis_tready = !q_full;
    assign push = s_axis_tvalid && !q_full;

    qalm_queue u_queue (
        .i_clk, .i_rst_n, .i_push(push), .i_item(in_item), .o_full(q_full),
        .i_pop(q_pop), .o_empty(q_empty), .o_item(q_item)
    );

    qalm_back u_back (
        .i_clk, .i_rst_n, .i_cfg(r_cfg), .i_empty(q_empty), .i_item(q_item),
        .o_pop(q_pop), .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_pwm_fr(fr), .o_pwm_fl(fl), .o_pwm_br(br), .o_pwm_bl(bl),
        .o_pitch(pe), .o_roll(re)
    );

    assign m_axis_tdata = {6'd0, re, pe, bl, br, fl, fr};
endmodule

// File: rtl/qalm_queue.sv
// Two-entry queue between the input front end and the back end.
// Depends on qalm_pkg.
module qalm_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  qalm_pkg::t_item  i_item,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output qalm_pkg::t_item  o_item
);
    qalm_pkg::t_item r_mem [2];
    logic            r_wp, r_rp;
    logic [1:0]      r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
        if (i_push) r_mem[r_wp] <= i_item;
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_item  = r_mem[r_rp];

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop) else $error("queue underflow");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count out of range");
`endif
endmodule

// File: rtl/qalm_cordic.sv
// Iterative vectoring CORDIC computing atan2(num, den) in 1/256 degree.
// One micro-rotation per cycle; depends on qalm_pkg.
module qalm_cordic (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [16:0] i_num,
    input  logic signed [16:0] i_den,
    output logic               o_done,
    output logic signed [17:0] o_angle
);
    localparam int W = 44;
    localparam logic [qalm_pkg::StepW-1:0] LastStep =
        qalm_pkg::StepW'(qalm_pkg::CordicSteps - 1);

    logic signed [W-1:0]  r_x, r_y;
    logic signed [31:0]   r_z, r_base;
    logic [qalm_pkg::StepW-1:0] r_i;
    logic                 r_busy, r_zero;
    logic signed [W-1:0]  dx, dy;
    logic signed [31:0]   atn, fin, rnd;
    logic signed [17:0] n_angle;

    assign dx  = r_x >>> r_i;
    assign dy  = r_y >>> r_i;
    assign atn = qalm_pkg::atan_entry(5'(r_i));
    assign fin = r_base + r_z + (32'sd1 <<< (15 - qalm_pkg::AngleFrac));
    assign rnd = fin >>> (16 - qalm_pkg::AngleFrac);

    always_comb begin
        if (r_zero) n_angle = '0;
        else if (rnd > qalm_pkg::HalfTurn) n_angle = 18'(qalm_pkg::HalfTurn);
        else if (rnd < -qalm_pkg::HalfTurn) n_angle = -18'(qalm_pkg::HalfTurn);
        else n_angle = rnd[17:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
                r_z    <= '0;
                r_zero <= (i_num == 0) && (i_den == 0);
                if (i_den < 0) begin
                    r_base <= (i_num >= 0) ? 32'sd11796480 : -32'sd11796480;
                    r_x <= W'(-i_den) <<< 24;
                    r_y <= W'(-i_num) <<< 24;
                end else begin
                    r_base <= '0;
                    r_x <= W'(i_den) <<< 24;
                    r_y <= W'(i_num) <<< 24;
                end
            end else if (r_busy) begin
                if (r_y >= 0) begin
                    r_x <= r_x + dy; r_y <= r_y - dx; r_z <= r_z + atn;
                end else begin
                    r_x <= r_x - dy; r_y <= r_y + dx; r_z <= r_z - atn;
                end
                r_i <= r_i + 1'b1;
                if (r_i == LastStep) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
            if (o_done) o_angle <= n_angle;
        end
    end

    logic r_done_d;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_done_d <= 1'b0;
        else r_done_d <= o_done;
    end

`ifndef SYNTHESIS
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("done held");
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_start) else $error("restart while busy");
    a_done_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done_d |-> !r_busy || $past(i_start)) else $error("busy after done");
`endif
endmodule

// File: rtl/qalm_back.sv
// Back end: command handling, tilt filtering and motor mixing.
// Depends on qalm_pkg and qalm_cordic.
module qalm_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  qalm_pkg::t_cfg   i_cfg,
    input  logic             i_empty,
    input  qalm_pkg::t_item  i_item,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [7:0]       o_pwm_fr,
    output logic [7:0]       o_pwm_fl,
    output logic [7:0]       o_pwm_br,
    output logic [7:0]       o_pwm_bl,
    output logic [16:0]      o_pitch,
    output logic [16:0]      o_roll
);
    typedef enum logic [2:0] {
        S_IDLE, S_PITCH, S_ROLL, S_FILT, S_CORR, S_MIX
    } t_state;

    t_state r_state;
    logic signed [11:0] r_thr, r_pit, r_rol, r_yaw;
    logic [1:0]         r_esc;
    logic signed [17:0] r_fp, r_fr, r_rawp;
    logic signed [14:0] r_pc, r_rc;
    logic signed [16:0] r_num, r_den;
    logic [15:0]        r_ay;
    logic               r_start;
    logic               c_done;
    logic signed [17:0] c_angle;

    qalm_cordic u_cordic (
        .i_clk, .i_rst_n, .i_start(r_start), .i_num(r_num), .i_den(r_den),
        .o_done(c_done), .o_angle(c_angle)
    );

    function automatic logic signed [11:0] sat(input logic signed [12:0] v);
        if (v > qalm_pkg::OffsetLimit) return 12'(qalm_pkg::OffsetLimit);
        if (v < -qalm_pkg::OffsetLimit) return -12'(qalm_pkg::OffsetLimit);
        return v[11:0];
    endfunction

    function automatic logic signed [17:0] smooth(input logic signed [17:0] o,
                                                 input logic signed [17:0] n,
                                                 input logic [8:0] a9);
        logic [8:0] a;
        logic signed [28:0] s;
        a = (a9 > 9'd256) ? 9'd256 : a9;
        s = 29'(o) * $signed({1'b0, 9'd256 - a}) + 29'(n) * $signed({1'b0, a}) + 29'sd128;
        return 18'(s >>> 8);
    endfunction

    function automatic logic signed [14:0] corr(input logic signed [17:0] f,
                                               input qalm_pkg::t_cfg c);
        logic [17:0] mag;
        logic [23:0] pr;
        mag = f[17] ? 18'(-f) : 18'(f);
        if (mag < {6'd0, c.dead}) return '0;
        pr = mag * c.gain;
        return f[17] ? -15'(pr >> qalm_pkg::AngleFrac) : 15'(pr >> qalm_pkg::AngleFrac);
    endfunction

    function automatic logic [7:0] clp(input logic signed [16:0] v);
        if (v < 0) return 8'd0;
        if (v > 255) return 8'd255;
        return v[7:0];
    endfunction

    logic signed [12:0] st, th13;
    logic signed [16:0] th, pc, rc, yw, p, r;
    assign st   = 13'($signed({1'b0, i_cfg.step}));
    assign th13 = 13'($signed({1'b0, i_cfg.home}));
    assign th = 17'(r_thr); assign pc = 17'(r_pc); assign rc = 17'(r_rc);
    assign yw = 17'(r_yaw); assign p = 17'(r_pit); assign r = 17'(r_rol);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_thr <= 12'sd128; r_pit <= '0; r_rol <= '0; r_yaw <= '0;
            r_esc <= 2'd0; r_fp <= '0; r_fr <= '0;
            r_start <= 1'b0; o_pop <= 1'b0; o_valid <= 1'b0;
        end else begin
            r_start <= 1'b0;
            o_pop   <= 1'b0;
            unique case (r_state)
                S_IDLE: if (!i_empty && !o_pop) begin
                    o_pop <= 1'b1;
                    if (i_item.mode) begin
                        r_num   <= 17'($signed(i_item.ax));
                        r_den   <= -17'($signed(i_item.az));
                        r_ay    <= i_item.ay;
                        r_start <= 1'b1;
                        r_state <= S_PITCH;
                    end else if (r_esc == 2'd1) begin
                        r_esc <= (i_item.cmd == qalm_pkg::KeyBrack) ? 2'd2 : 2'd0;
                    end else if (r_esc == 2'd2) begin
                        r_esc <= 2'd0;
                        case (i_item.cmd)
                            "A": r_thr <= sat(13'(r_thr) + st);
                            "B": r_thr <= sat(13'(r_thr) - st);
                            "C": r_yaw <= sat(13'(r_yaw) + st);
                            "D": r_yaw <= sat(13'(r_yaw) - st);
                            default: ;
                        endcase
                    end else begin
                        case (i_item.cmd)
                            "w": r_pit <= sat(13'(r_pit) + st);
                            "s": r_pit <= sat(13'(r_pit) - st);
                            "d": r_rol <= sat(13'(r_rol) + st);
                            "a": r_rol <= sat(13'(r_rol) - st);
                            "i": r_thr <= sat(13'(r_thr) + st);
                            "k": r_thr <= sat(13'(r_thr) - st);
                            "l": r_yaw <= sat(13'(r_yaw) + st);
                            "j": r_yaw <= sat(13'(r_yaw) - st);
                            qalm_pkg::KeySpace: begin
                                r_pit <= '0; r_rol <= '0; r_yaw <= '0;
                                r_thr <= sat(th13);
                            end
                            qalm_pkg::KeyEsc: r_esc <= 2'd1;
                            default: ;
                        endcase
                    end
                end
                S_PITCH: if (c_done) begin
                    r_num   <= 17'($signed(r_ay));
                    r_start <= 1'b1;
                    r_state <= S_ROLL;
                end
                S_ROLL: begin
                    if (c_done) r_state <= S_FILT;
                    if (r_start) r_rawp <= c_angle;
                end
                S_FILT: begin
                    r_fp <= smooth(r_fp, r_rawp, i_cfg.alpha);
                    r_fr <= smooth(r_fr, c_angle, i_cfg.alpha);
                    r_state <= S_CORR;
                end
                S_CORR: begin
                    r_pc <= corr(r_fp, i_cfg);
                    r_rc <= corr(r_fr, i_cfg);
                    r_state <= S_MIX;
                end
                S_MIX: if (!o_valid) begin
                    o_pwm_fr <= clp(th + pc - rc - yw + p - r);
                    o_pwm_fl <= clp(th + pc + rc + yw + p + r);
                    o_pwm_br <= clp(th - pc - rc + yw - p - r);
                    o_pwm_bl <= clp(th - pc + rc - yw - p + r);
                    o_pitch  <= r_fp[16:0];
                    o_roll   <= r_fr[16:0];
                    o_valid  <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
            if (o_valid && i_ready && !(r_state == S_MIX)) o_valid <= 1'b0;
            else if (o_valid && i_ready && r_state == S_MIX) o_valid <= 1'b0;
        end
    end

`ifndef SYNTHESIS
    a_offset_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_thr <= 1023) && (r_thr >= -1023) && (r_yaw <= 1023) && (r_yaw >= -1023))
        else $error("offset out of range");
    a_esc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_esc != 2'd3) else $error("bad escape phase");
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_pwm_fr)) else $error("result lost");
`endif
endmodule
